// ===== design/approx_tandem_repeat_finder_assert.svh =====
// Assertion macros shared by the tandem repeat finder modules.
// Depends on nothing; included by the controller and the datapath.
// Setting ASSERT_OFF turns every macro into an empty body.
`ifndef APPROX_TANDEM_REPEAT_FINDER_ASSERT_SVH
`define APPROX_TANDEM_REPEAT_FINDER_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ATRF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ATRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ATRF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ATRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/atrf_pkg.sv =====
// Shared constants, register indexes and controller/datapath interface types
// for the approximate tandem repeat finder. Depends on nothing.
package atrf_pkg;

    // Field widths of the ports.
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 10;
    localparam int PER_W      = 3;
    localparam int UNIT_BYTES = 6;
    localparam int UNIT_W     = UNIT_BYTES * CHAR_W;
    localparam int LEN_SAT    = 1023;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int MISS_W     = CFG_DATA_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RST_MAX_PERIOD     = 3'd6;
    localparam logic [CFG_DATA_W-1:0] RST_MISMATCH_LIMIT = 3'd1;

    // Default sizing.
    localparam int DEF_MAX_LEN    = 1024;
    localparam int DEF_MAX_PERIOD = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic search_init;
        logic next_start;
        logic pair_begin;
        logic issue_unit;
        logic issue_cmp;
        logic pair_end;
        logic report;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_end;
        logic pair_skip;
        logic last_j;
        logic copy_start;
        logic copy_fits;
        logic abort;
        logic rd_busy;
    } t_dp_status;

endpackage

// ===== design/atrf_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module atrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/atrf_ctrl.sv =====
// Controller state machine of the tandem repeat finder: load, search sequencing
// and result hand-off. Depends on atrf_pkg and the assertion macro header.
`include "approx_tandem_repeat_finder_assert.svh"
module atrf_ctrl
    import atrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_last_char,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PAIR,
        S_UNIT,
        S_WALK,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_dp_cmd n_cmd;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    n_cmd.load_wr = 1'b1;
                    if (i_last_char) begin
                        n_cmd.search_init = 1'b1;
                        n_state           = S_PAIR;
                    end
                end
            end
            S_PAIR: begin
                if (i_status.search_end) begin
                    n_state = S_DONE;
                end else if (i_status.pair_skip) begin
                    n_cmd.next_start = 1'b1;
                end else begin
                    n_cmd.pair_begin = 1'b1;
                    n_state          = S_UNIT;
                end
            end
            S_UNIT: begin
                n_cmd.issue_unit = 1'b1;
                if (i_status.last_j) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // Stop on too many mismatches or when the next copy would reach the end.
                if (i_status.abort) begin
                    n_state = S_DRAIN;
                end else if (i_status.copy_start && !i_status.copy_fits) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cmd.issue_cmp = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_status.rd_busy) begin
                    n_cmd.pair_end = 1'b1;
                    n_state        = S_PAIR;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_cmd.report = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_cmd.report) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = n_cmd;

    // At most one search command is given in any cycle.
    `ATRF_ASSERT_IMPL(a_ctrl_one_cmd, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.next_start, o_cmd.pair_begin, o_cmd.issue_unit,
                  o_cmd.issue_cmp, o_cmd.pair_end, o_cmd.report}),
        "controller issued two search commands at once")
    // A report is always followed by a valid result.
    `ATRF_ASSERT_NEXT(a_ctrl_report_valid, i_clk, i_rst_n, o_cmd.report, o_out_valid,
        "result not presented after report")
    // No memory read is issued while characters are being loaded.
    `ATRF_ASSERT_IMPL(a_ctrl_no_read_in_load, i_clk, i_rst_n, o_in_ready,
        !(o_cmd.issue_unit || o_cmd.issue_cmp), "memory read issued during load")

endmodule

// ===== design/atrf_dp.sv =====
// Datapath of the tandem repeat finder: sequence memory, configuration
// registers, search counters, mismatch tally and best-result registers.
// Depends on atrf_pkg, atrf_ram and the assertion macro header.
`include "approx_tandem_repeat_finder_assert.svh"
module atrf_dp
    import atrf_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int MAX_PERIOD = DEF_MAX_PERIOD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CHAR_W-1:0]     i_seq_char,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [LEN_W-1:0]      o_repeat_length,
    output logic [PER_W-1:0]      o_unit_length,
    output logic [UNIT_W-1:0]     o_unit_chars,
    output logic                  o_overflowed
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(MAX_PERIOD + 2);
    localparam int JW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int UB = (MAX_PERIOD < UNIT_BYTES) ? MAX_PERIOD : UNIT_BYTES;
    localparam int XW = (CW > LEN_W) ? CW : LEN_W;
    localparam int KW = (PW > CFG_DATA_W) ? PW : CFG_DATA_W;

    // Configuration and load state.
    logic [CFG_DATA_W-1:0] r_max_period;
    logic [CFG_DATA_W-1:0] r_mismatch_limit;
    logic [CW-1:0]         r_count;
    logic                  r_ovf;

    // Search counters.
    logic [CW-1:0] r_start;
    logic [PW-1:0] r_k;
    logic [PW-1:0] r_top;
    logic [CW-1:0] r_addr;
    logic [JW-1:0] r_j;

    // Read return tag.
    logic          r_tag_vld;
    logic          r_tag_cmp;
    logic          r_tag_end;
    logic [JW-1:0] r_tag_j;

    // Walk state and best result.
    logic [MISS_W-1:0] r_miss;
    logic [CW-1:0]     r_total;
    logic              r_abort;
    logic [CW-1:0]     r_best_len;
    logic [PW-1:0]     r_best_per;
    logic [UNIT_W-1:0] r_best_unit;
    logic [CHAR_W-1:0] r_unit [MAX_PERIOD];

    // Result register.
    logic [LEN_W-1:0]  r_out_len;
    logic [PER_W-1:0]  r_out_per;
    logic [UNIT_W-1:0] r_out_unit;
    logic              r_out_ovf;

    logic              wr_en;
    logic              rd_en;
    logic [CHAR_W-1:0] rd_data;
    logic              last_j;
    logic [KW-1:0]     cfg_per_ext;
    logic [PW-1:0]     n_top;
    logic              mismatch;
    logic [MISS_W-1:0] n_miss;
    logic              over;
    logic              ret_cmp;
    logic [UNIT_W-1:0] n_unit;
    logic [XW-1:0]     len_ext;
    logic [LEN_W-1:0]  n_out_len;
    logic [KW-1:0]     per_ext;

    // Sequence memory.
    atrf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_LEN)
    ) u_seq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_seq_char),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign wr_en  = i_cmd.load_wr && (r_count != CW'(MAX_LEN));
    assign rd_en  = i_cmd.issue_unit || i_cmd.issue_cmp;
    assign last_j = (r_j == JW'(r_k - PW'(1)));

    // Effective period limit, saturated to the built-in maximum.
    assign cfg_per_ext = KW'(r_max_period);
    assign n_top = (cfg_per_ext > KW'(MAX_PERIOD)) ? PW'(MAX_PERIOD) : PW'(cfg_per_ext);

    // Compare a returning copy character with the stored unit character.
    assign ret_cmp  = r_tag_vld && r_tag_cmp && !r_abort;
    assign mismatch = (rd_data != r_unit[r_tag_j]);
    assign n_miss   = r_miss + MISS_W'(mismatch);
    assign over     = (n_miss > MISS_W'(r_mismatch_limit));

    // Pack the current unit, bytes beyond the period left at zero.
    always_comb begin
        n_unit = '0;
        for (int b = 0; b < UB; b++) begin
            if (PW'(b) < r_k) begin
                n_unit[b*CHAR_W +: CHAR_W] = r_unit[JW'(b)];
            end
        end
    end

    // Saturate the reported length and fit the period to its field.
    assign len_ext   = XW'(r_best_len);
    assign n_out_len = (len_ext > XW'(LEN_SAT)) ? LEN_W'(LEN_SAT) : len_ext[LEN_W-1:0];
    assign per_ext   = KW'(r_best_per);

    // Status towards the controller.
    assign o_status.search_end = (r_start == r_count);
    assign o_status.pair_skip  = (r_k > r_top) ||
                                 ((CW+1)'(r_start) + (CW+1)'(r_k) >= (CW+1)'(r_count));
    assign o_status.last_j     = last_j;
    assign o_status.copy_start = (r_j == '0);
    assign o_status.copy_fits  = ((CW+1)'(r_addr) + (CW+1)'(r_k) < (CW+1)'(r_count));
    assign o_status.abort      = r_abort;
    assign o_status.rd_busy    = r_tag_vld;

    // Control registers: configuration, fill count, overflow, read tag, abort.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_period     <= RST_MAX_PERIOD;
            r_mismatch_limit <= RST_MISMATCH_LIMIT;
            r_count          <= '0;
            r_ovf            <= 1'b0;
            r_tag_vld        <= 1'b0;
            r_abort          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_PERIOD:     r_max_period     <= i_cfg_data;
                    CFG_MISMATCH_LIMIT: r_mismatch_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_wr) begin
                if (wr_en) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.report) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            r_tag_vld <= rd_en;
            if (i_cmd.pair_begin) begin
                r_abort <= 1'b0;
            end else if (ret_cmp && over) begin
                r_abort <= 1'b1;
            end
        end
    end

    // Search counters, unit capture, mismatch walk and best result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_start     <= '0;
            r_k         <= PW'(1);
            r_top       <= n_top;
            r_best_len  <= '0;
            r_best_per  <= '0;
            r_best_unit <= '0;
        end else if (i_cmd.next_start) begin
            r_start <= r_start + CW'(1);
            r_k     <= PW'(1);
        end
        if (i_cmd.pair_begin) begin
            r_addr  <= r_start;
            r_j     <= '0;
            r_miss  <= '0;
            r_total <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + CW'(1);
            r_j    <= last_j ? '0 : r_j + JW'(1);
        end
        if (rd_en) begin
            r_tag_cmp <= i_cmd.issue_cmp;
            r_tag_end <= last_j;
            r_tag_j   <= r_j;
        end
        if (r_tag_vld && !r_tag_cmp) begin
            r_unit[r_tag_j] <= rd_data;
        end
        if (ret_cmp && !over) begin
            r_miss <= n_miss;
            if (r_tag_end) begin
                r_total <= r_total + CW'(r_k);
            end
        end
        if (i_cmd.pair_end) begin
            if (r_total > r_best_len) begin
                r_best_len  <= r_total;
                r_best_per  <= r_k;
                r_best_unit <= n_unit;
            end
            r_k <= r_k + PW'(1);
        end
        if (i_cmd.report) begin
            r_out_len  <= n_out_len;
            r_out_per  <= per_ext[PER_W-1:0];
            r_out_unit <= r_best_unit;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_repeat_length = r_out_len;
    assign o_unit_length   = r_out_per;
    assign o_unit_chars    = r_out_unit;
    assign o_overflowed    = r_out_ovf;

    // Every read of the sequence memory lies below the fill count.
    `ATRF_ASSERT_IMPL(a_dp_read_in_range, i_clk, i_rst_n, rd_en, r_addr < r_count,
        "sequence read beyond stored characters")
    // Once a walk has aborted no further copy character is fetched.
    `ATRF_ASSERT_IMPL(a_dp_no_cmp_after_abort, i_clk, i_rst_n, r_abort, !i_cmd.issue_cmp,
        "copy read issued after mismatch limit exceeded")
    // The kept mismatch tally never exceeds the limit.
    `ATRF_ASSERT_IMPL(a_dp_miss_in_limit, i_clk, i_rst_n, r_tag_vld && r_tag_cmp,
        r_miss <= MISS_W'(r_mismatch_limit), "mismatch tally above limit")

endmodule

// ===== design/approx_tandem_repeat_finder.sv =====
// Approximate tandem repeat finder. Characters are loaded one per cycle; the
// transaction carrying the last character starts a search over every start
// position and every period up to the configured limit, capped at MAX_PERIOD,
// and one result transaction follows. The search reads the sequence memory
// through its single read port, one character per cycle while it fetches a
// unit or walks the copies: each start and period k that is tested is first
// checked, then its unit of k characters is fetched, then the characters of
// the following copies are read in turn, and finally the walk is stopped and
// the pair is scored. A walk cut short by too many mismatches reads one
// further character that it discards. For a random sequence and a mismatch
// limit of one, each walk reads about three characters. A new result waits
// until the previous one has been taken. No clearing pass is needed after
// reset.
// Depends on atrf_pkg, atrf_ctrl and atrf_dp.
module approx_tandem_repeat_finder
    import atrf_pkg::*;
#(
    parameter int MAX_LEN    = DEF_MAX_LEN,
    parameter int MAX_PERIOD = DEF_MAX_PERIOD
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Character input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CHAR_W-1:0]     i_seq_char,
    input  logic                  i_last_char,
    // Result output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LEN_W-1:0]      o_repeat_length,
    output logic [PER_W-1:0]      o_unit_length,
    output logic [UNIT_W-1:0]     o_unit_chars,
    output logic                  o_overflowed
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencing.
    atrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_char (i_last_char),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic.
    atrf_dp #(
        .MAX_LEN    (MAX_LEN),
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_seq_char      (i_seq_char),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_repeat_length (o_repeat_length),
        .o_unit_length   (o_unit_length),
        .o_unit_chars    (o_unit_chars),
        .o_overflowed    (o_overflowed)
    );

endmodule
